// File: rtl/brw_pkg.sv
package brw_pkg;

    localparam int MAX_CAPACITY_LOG2_DEF = 16;
    localparam int QUEUE_DEPTH_DEF       = 4;
    localparam int CFG_INDEX_W           = 2;
    localparam int CFG_DATA_W            = 32;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY_LOG2  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MSG_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PADDING_TYPE   = 2'd2;

    localparam logic [4:0]  CAPACITY_LOG2_RST  = 5'd16;
    localparam logic [13:0] MAX_MSG_LENGTH_RST = 14'd8192;
    localparam logic [31:0] PADDING_TYPE_RST   = 32'hFFFF_FFFF;

    localparam int MIN_CAPACITY_LOG2 = 6;
    localparam int HDR_LEN           = 8;

    // write targets
    localparam logic [1:0] TGT_DATA   = 2'd0;
    localparam logic [1:0] TGT_INTENT = 2'd1;
    localparam logic [1:0] TGT_LATEST = 2'd2;
    localparam logic [1:0] TGT_TAIL   = 2'd3;

    localparam logic [3:0] FULL_WORD_BYTES = 4'd8;

    typedef enum logic [1:0] {
        CMD_ERR   = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2
    } t_cmd_op;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] type_id;
        logic [15:0]        msg_length;
        logic [63:0]        payload_word;
    } t_in;

    typedef struct packed {
        logic [1:0]  write_target;
        logic [15:0] write_offset;
        logic [63:0] write_value;
        logic [3:0]  valid_bytes;
        logic        error;
        logic        last;
    } t_out;

    // one classified item, expanded into writes by the back end
    typedef struct packed {
        t_cmd_op     op;
        logic        wrap;
        logic        publish;
        logic [15:0] pad_offset;
        logic [63:0] pad_value;
        logic [15:0] data_offset;
        logic [63:0] data_value;
        logic [3:0]  data_bytes;
        logic [63:0] record_start;
        logic [63:0] next_tail;
    } t_cmd;

endpackage

// File: rtl/brw_front.sv
module brw_front #(
    parameter int MAX_CAPACITY_LOG2 = brw_pkg::MAX_CAPACITY_LOG2_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [brw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [brw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  brw_pkg::t_in                    i_in_data,
    input  logic                            i_q_full,
    output logic                            o_q_push,
    output brw_pkg::t_cmd                   o_q_cmd
);
    localparam int CW   = MAX_CAPACITY_LOG2 + 1;
    localparam int AL_W = 17;
    localparam int CMPW = (CW > AL_W) ? CW : AL_W;

    logic [4:0]  r_capacity_log2;
    logic [13:0] r_max_len;
    logic [31:0] r_pad_type;

    logic [63:0] r_tail_count, n_tail_count;
    logic [63:0] r_record_start, n_record_start;
    logic [63:0] r_next_tail, n_next_tail;
    logic [15:0] r_write_ptr, n_write_ptr;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_msg_open, n_msg_open;

    logic [4:0]      lg;
    logic [CW-1:0]   cap;
    logic [CW-1:0]   mask;
    logic [CW-1:0]   off;
    logic [CW-1:0]   to_end;
    logic [63:0]     base;
    logic [AL_W-1:0] rec_len;
    logic [AL_W-1:0] aligned;
    logic [CMPW:0]   cap_plus_al;
    logic [63:0]     tail_nowrap;
    logic [63:0]     start_wrap;
    logic [63:0]     tail_wrap;
    logic            bad_type;
    logic            reject;
    logic            wrap;
    logic [15:0]     hdr_off;
    logic [63:0]     new_start;
    logic [63:0]     end_tail;
    logic [3:0]      nb;
    logic [63:0]     masked_word;
    logic            last_word;
    logic            accept;
    brw_pkg::t_cmd   cmd;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        if (r_capacity_log2 < 5'(brw_pkg::MIN_CAPACITY_LOG2)) begin
            lg = 5'(brw_pkg::MIN_CAPACITY_LOG2);
        end else if (r_capacity_log2 > 5'(MAX_CAPACITY_LOG2)) begin
            lg = 5'(MAX_CAPACITY_LOG2);
        end else begin
            lg = r_capacity_log2;
        end
    end

    assign cap     = CW'(1) << lg;
    assign mask    = cap - CW'(1);
    assign off     = r_tail_count[CW-1:0] & mask;
    assign to_end  = cap - off;
    assign base    = r_tail_count & ~(64'(mask));
    assign rec_len = AL_W'(i_in_data.msg_length) + AL_W'(brw_pkg::HDR_LEN);
    assign aligned = (rec_len + AL_W'(7)) & ~AL_W'(7);

    assign cap_plus_al = (CMPW+1)'(cap) + (CMPW+1)'(aligned);
    assign tail_nowrap = r_tail_count + 64'(aligned);
    assign start_wrap  = base + 64'(cap);
    assign tail_wrap   = base + 64'(cap_plus_al);

    assign bad_type = i_in_data.type_id[31] || (i_in_data.type_id == 32'sd0);
    assign reject   = (i_in_data.msg_length > {2'b00, r_max_len}) || bad_type
                   || (CMPW'(aligned) > CMPW'(cap));
    assign wrap     = CMPW'(to_end) < CMPW'(aligned);

    assign hdr_off   = wrap ? 16'd0 : 16'(off);
    assign new_start = wrap ? start_wrap : r_tail_count;
    assign end_tail  = wrap ? tail_wrap : tail_nowrap;

    // payload word: only the bytes still due are kept
    assign nb        = (r_bytes_left < 16'd8) ? r_bytes_left[3:0] : brw_pkg::FULL_WORD_BYTES;
    assign last_word = r_bytes_left <= 16'd8;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            masked_word[i*8 +: 8] = (4'(i) < nb) ? i_in_data.payload_word[i*8 +: 8] : 8'd0;
        end
    end

    always_comb begin
        cmd              = '0;
        cmd.op           = brw_pkg::CMD_ERR;
        n_tail_count     = r_tail_count;
        n_record_start   = r_record_start;
        n_next_tail      = r_next_tail;
        n_write_ptr      = r_write_ptr;
        n_bytes_left     = r_bytes_left;
        n_msg_open       = r_msg_open;
        if (!i_in_data.kind) begin
            if (!reject) begin
                cmd.op           = brw_pkg::CMD_START;
                cmd.wrap         = wrap;
                cmd.publish      = (i_in_data.msg_length == 16'd0);
                cmd.pad_offset   = 16'(off);
                cmd.pad_value    = {r_pad_type, 32'(to_end)};
                cmd.data_offset  = hdr_off;
                cmd.data_value   = {i_in_data.type_id, 15'd0, rec_len};
                cmd.data_bytes   = brw_pkg::FULL_WORD_BYTES;
                cmd.record_start = new_start;
                cmd.next_tail    = end_tail;
                n_record_start   = new_start;
                n_next_tail      = end_tail;
                n_write_ptr      = hdr_off + 16'(brw_pkg::HDR_LEN);
                n_bytes_left     = i_in_data.msg_length;
                n_msg_open       = 1'b1;
                if (i_in_data.msg_length == 16'd0) begin
                    // empty message is published at once
                    n_tail_count = end_tail;
                    n_msg_open   = 1'b0;
                end
            end
        end else if (r_msg_open) begin
            cmd.op           = brw_pkg::CMD_DATA;
            cmd.publish      = last_word;
            cmd.data_offset  = r_write_ptr;
            cmd.data_value   = masked_word;
            cmd.data_bytes   = nb;
            cmd.record_start = r_record_start;
            cmd.next_tail    = r_next_tail;
            n_write_ptr      = r_write_ptr + 16'd8;
            n_bytes_left     = r_bytes_left - 16'(nb);
            if (last_word) begin
                n_tail_count = r_next_tail;
                n_msg_open   = 1'b0;
            end
        end
    end

    assign o_q_push = accept;
    assign o_q_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity_log2 <= brw_pkg::CAPACITY_LOG2_RST;
            r_max_len       <= brw_pkg::MAX_MSG_LENGTH_RST;
            r_pad_type      <= brw_pkg::PADDING_TYPE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                brw_pkg::CFG_CAPACITY_LOG2:  r_capacity_log2 <= i_cfg_data[4:0];
                brw_pkg::CFG_MAX_MSG_LENGTH: r_max_len       <= i_cfg_data[13:0];
                brw_pkg::CFG_PADDING_TYPE:   r_pad_type      <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_count   <= '0;
            r_record_start <= '0;
            r_next_tail    <= '0;
            r_write_ptr    <= '0;
            r_bytes_left   <= '0;
            r_msg_open     <= 1'b0;
        end else if (accept) begin
            r_tail_count   <= n_tail_count;
            r_record_start <= n_record_start;
            r_next_tail    <= n_next_tail;
            r_write_ptr    <= n_write_ptr;
            r_bytes_left   <= n_bytes_left;
            r_msg_open     <= n_msg_open;
        end
    end

endmodule

// File: rtl/brw_queue.sv
module brw_queue #(
    parameter int DEPTH = brw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  brw_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output brw_pkg::t_cmd o_head,
    output logic          o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    brw_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_count;

    assign o_full  = r_count == (AW+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (AW+1)'(1);
                2'b01:   r_count <= r_count - (AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/brw_back.sv
module brw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  brw_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output brw_pkg::t_out o_res_data
);
    typedef enum logic [6:0] {
        S_FIRST  = 7'b0000001,
        S_INTENT = 7'b0000010,
        S_PAD    = 7'b0000100,
        S_DATA   = 7'b0001000,
        S_LATEST = 7'b0010000,
        S_TAIL   = 7'b0100000,
        S_ERR    = 7'b1000000
    } t_step;

    t_step          r_step;
    t_step          cur;
    t_step          nxt;
    logic           done;
    logic           adv;
    brw_pkg::t_out  res;
    brw_pkg::t_out  r_res;
    logic           r_res_valid;

    assign adv = !i_empty && (!r_res_valid || i_res_ready);

    always_comb begin
        if (r_step == S_FIRST) begin
            case (i_head.op)
                brw_pkg::CMD_START: cur = S_INTENT;
                brw_pkg::CMD_DATA:  cur = S_DATA;
                default:            cur = S_ERR;
            endcase
        end else begin
            cur = r_step;
        end
    end

    always_comb begin
        res  = '0;
        nxt  = S_FIRST;
        done = 1'b0;
        case (cur)
            S_INTENT: begin
                res.write_target = brw_pkg::TGT_INTENT;
                res.write_value  = i_head.next_tail;
                res.valid_bytes  = brw_pkg::FULL_WORD_BYTES;
                nxt              = i_head.wrap ? S_PAD : S_DATA;
            end
            S_PAD: begin
                res.write_target = brw_pkg::TGT_DATA;
                res.write_offset = i_head.pad_offset;
                res.write_value  = i_head.pad_value;
                res.valid_bytes  = brw_pkg::FULL_WORD_BYTES;
                nxt              = S_DATA;
            end
            S_DATA: begin
                res.write_target = brw_pkg::TGT_DATA;
                res.write_offset = i_head.data_offset;
                res.write_value  = i_head.data_value;
                res.valid_bytes  = i_head.data_bytes;
                nxt              = S_LATEST;
                done             = !i_head.publish;
            end
            S_LATEST: begin
                res.write_target = brw_pkg::TGT_LATEST;
                res.write_value  = i_head.record_start;
                res.valid_bytes  = brw_pkg::FULL_WORD_BYTES;
                nxt              = S_TAIL;
            end
            S_TAIL: begin
                res.write_target = brw_pkg::TGT_TAIL;
                res.write_value  = i_head.next_tail;
                res.valid_bytes  = brw_pkg::FULL_WORD_BYTES;
                done             = 1'b1;
            end
            default: begin
                // rejected start or stray payload
                res.error = 1'b1;
                done      = 1'b1;
            end
        endcase
        res.last = done;
    end

    assign o_pop       = adv && done;
    assign o_res_valid = r_res_valid;
    assign o_res_data  = r_res;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_FIRST;
            r_res_valid <= 1'b0;
        end else if (adv) begin
            r_step      <= done ? S_FIRST : nxt;
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

endmodule

// File: rtl/broadcast_ring_record_writer_top.sv
// first write of an item is registered in the command queue, then in the result register
// throughput: one write per cycle while i_res_ready holds; payload items give one write
// (three closing a message), start items one to five; one result register in the back end
// a command queue, 4 entries by default, lets input transfers continue while writes drain
// reset: synchronous active-low i_rst_n clears ring state and queue, loads register defaults
module broadcast_ring_record_writer_top #(
    parameter int MAX_CAPACITY_LOG2 = brw_pkg::MAX_CAPACITY_LOG2_DEF,
    parameter int QUEUE_DEPTH       = brw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [brw_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [brw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  brw_pkg::t_in                    i_in_data,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output brw_pkg::t_out                   o_res_data
);
    logic          q_full;
    logic          q_push;
    brw_pkg::t_cmd q_cmd;
    logic          q_pop;
    brw_pkg::t_cmd q_head;
    logic          q_empty;

    assign o_cfg_ready = 1'b1;

    brw_front #(
        .MAX_CAPACITY_LOG2 (MAX_CAPACITY_LOG2)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd)
    );

    brw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    brw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res_data  (o_res_data)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int RING_LOG2_MAX = brw_pkg::MAX_CAPACITY_LOG2_DEF;

    // index with no register behind it, writes to it are dropped
    localparam logic [brw_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam brw_pkg::t_out REJECT_WRITE = '{
        write_target: brw_pkg::TGT_DATA,
        write_offset: 16'd0,
        write_value:  64'd0,
        valid_bytes:  4'd0,
        error:        1'b1,
        last:         1'b1
    };

    typedef struct packed {
        logic                            is_cfg;
        logic [brw_pkg::CFG_INDEX_W-1:0] cfg_index;
        logic [brw_pkg::CFG_DATA_W-1:0]  cfg_data;
        brw_pkg::t_in                    item;
        logic                            expect_reject;
    } t_stim_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [brw_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [brw_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    logic          in_valid  = 1'b0;
    logic          in_ready;
    brw_pkg::t_in  in_data   = '0;
    logic          res_valid;
    logic          res_ready = 1'b0;
    brw_pkg::t_out res_data;

    // ring model
    logic [4:0]  cap_log2_r;
    logic [13:0] max_len_r;
    logic [31:0] pad_type_r;
    logic [63:0] ring_tail;
    logic [63:0] rec_start;
    logic [63:0] rec_end;
    logic [15:0] wr_ptr;
    logic [15:0] bytes_due;
    logic        record_open;

    brw_pkg::t_out ring_writes_due[$];

    int unsigned send_idle_pct = 27;
    int unsigned recv_idle_pct = 83;
    logic        holding       = 1'b0;

    int unsigned fail_count      = 0;
    int unsigned items_accepted  = 0;
    int unsigned writes_checked  = 0;
    int unsigned rejects_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned cycle_count     = 0;

    broadcast_ring_record_writer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_ready <= !holding && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) begin
            take_ring_write(res_data);
        end
    end

    function automatic logic [63:0] ring_bytes();
        int unsigned lg;
        lg = 32'(cap_log2_r);
        if (lg < brw_pkg::MIN_CAPACITY_LOG2) lg = brw_pkg::MIN_CAPACITY_LOG2;
        if (lg > RING_LOG2_MAX) lg = RING_LOG2_MAX;
        return 64'd1 << lg;
    endfunction

    function automatic brw_pkg::t_out ring_write(input logic [1:0] tgt, input logic [63:0] off,
                                                 input logic [63:0] val, input logic [3:0] nb);
        brw_pkg::t_out w;
        w = '0;
        w.write_target = tgt;
        w.write_offset = off[15:0];
        w.write_value  = val;
        w.valid_bytes  = nb;
        return w;
    endfunction

    task automatic close_record();
        ring_writes_due.push_back(ring_write(brw_pkg::TGT_LATEST, 64'd0, rec_start,
                                             brw_pkg::FULL_WORD_BYTES));
        ring_writes_due.push_back(ring_write(brw_pkg::TGT_TAIL, 64'd0, rec_end,
                                             brw_pkg::FULL_WORD_BYTES));
        ring_tail   = rec_end;
        record_open = 1'b0;
        bytes_due   = '0;
    endtask

    task automatic predict_ring_writes(input brw_pkg::t_in it);
        logic [63:0]   cap;
        logic [63:0]   rec_len;
        logic [63:0]   aligned;
        logic [63:0]   cur;
        logic [63:0]   off;
        logic [63:0]   to_end;
        logic [63:0]   end_tail;
        logic [63:0]   val;
        logic [3:0]    nb;
        brw_pkg::t_out w;
        if (it.kind == 1'b0) begin
            cap     = ring_bytes();
            rec_len = 64'(it.msg_length) + 64'(brw_pkg::HDR_LEN);
            aligned = (rec_len + 64'd7) & ~64'd7;
            if (it.msg_length > max_len_r || it.type_id[31] || it.type_id == 0
                    || aligned > cap) begin
                ring_writes_due.push_back(REJECT_WRITE);
            end else begin
                cur      = ring_tail;
                off      = cur & (cap - 64'd1);
                to_end   = cap - off;
                end_tail = cur + aligned;
                if (to_end < aligned) begin
                    // pad out the end of the ring and restart at offset 0
                    ring_writes_due.push_back(ring_write(brw_pkg::TGT_INTENT, 64'd0,
                                                         end_tail + to_end,
                                                         brw_pkg::FULL_WORD_BYTES));
                    ring_writes_due.push_back(ring_write(brw_pkg::TGT_DATA, off,
                                                         {pad_type_r, to_end[31:0]},
                                                         brw_pkg::FULL_WORD_BYTES));
                    cur = cur + to_end;
                    off = 64'd0;
                end else begin
                    ring_writes_due.push_back(ring_write(brw_pkg::TGT_INTENT, 64'd0, end_tail,
                                                         brw_pkg::FULL_WORD_BYTES));
                end
                ring_writes_due.push_back(ring_write(brw_pkg::TGT_DATA, off,
                                                     {it.type_id, rec_len[31:0]},
                                                     brw_pkg::FULL_WORD_BYTES));
                rec_start   = cur;
                rec_end     = cur + aligned;
                wr_ptr      = off[15:0] + 16'd8;
                bytes_due   = it.msg_length;
                record_open = 1'b1;
                if (it.msg_length == 0) close_record();
            end
        end else if (!record_open) begin
            ring_writes_due.push_back(REJECT_WRITE);
        end else begin
            nb  = (bytes_due < 16'd8) ? bytes_due[3:0] : brw_pkg::FULL_WORD_BYTES;
            val = (nb == brw_pkg::FULL_WORD_BYTES)
                ? it.payload_word
                : it.payload_word & ((64'd1 << (nb * 8)) - 64'd1);
            ring_writes_due.push_back(ring_write(brw_pkg::TGT_DATA, 64'(wr_ptr), val, nb));
            wr_ptr    = wr_ptr + 16'd8;
            bytes_due = bytes_due - 16'(nb);
            if (bytes_due == 0) close_record();
        end
        w = ring_writes_due.pop_back();
        w.last = 1'b1;
        ring_writes_due.push_back(w);
    endtask

    task automatic take_ring_write(input brw_pkg::t_out got);
        brw_pkg::t_out want;
        writes_checked++;
        if (got.error) rejects_checked++;
        if (ring_writes_due.size() == 0) begin
            $error("unexpected ring write: target %0d offset %h value %h",
                   got.write_target, got.write_offset, got.write_value);
            fail_count++;
        end else begin
            want = ring_writes_due.pop_front();
            if (got.write_target !== want.write_target) begin
                $error("write_target: expected %0d, got %0d",
                       want.write_target, got.write_target);
                fail_count++;
            end
            if (got.write_offset !== want.write_offset) begin
                $error("write_offset: expected %h, got %h", want.write_offset, got.write_offset);
                fail_count++;
            end
            if (got.write_value !== want.write_value) begin
                $error("write_value: expected %h, got %h", want.write_value, got.write_value);
                fail_count++;
            end
            if (got.valid_bytes !== want.valid_bytes) begin
                $error("valid_bytes: expected %0d, got %0d", want.valid_bytes, got.valid_bytes);
                fail_count++;
            end
            if (got.error !== want.error) begin
                $error("error: expected %0b, got %0b", want.error, got.error);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                fail_count++;
            end
        end
    endtask

    function automatic brw_pkg::t_in start_item(input logic [31:0] ty, input logic [15:0] len);
        brw_pkg::t_in it;
        it.kind         = 1'b0;
        it.type_id      = ty;
        it.msg_length   = len;
        it.payload_word = {$urandom, $urandom};
        return it;
    endfunction

    function automatic brw_pkg::t_in word_item(input logic [63:0] w);
        brw_pkg::t_in it;
        it.kind         = 1'b1;
        it.type_id      = $urandom;
        it.msg_length   = 16'($urandom_range(0, 16'hFFFF));
        it.payload_word = w;
        return it;
    endfunction

    function automatic t_stim_row item_row(input brw_pkg::t_in it, input logic rej);
        t_stim_row row;
        row = '0;
        row.item = it;
        row.expect_reject = rej;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(input logic [brw_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [brw_pkg::CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = '0;
        row.is_cfg    = 1'b1;
        row.cfg_index = idx;
        row.cfg_data  = data;
        return row;
    endfunction

    task automatic send_item(input brw_pkg::t_in it, input logic typed_reject = 1'b0);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_accepted++;
        if (typed_reject) ring_writes_due.push_back(REJECT_WRITE);
        else predict_ring_writes(it);
    endtask

    task automatic send_cfg(input logic [brw_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [brw_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_writes++;
        case (idx)
            brw_pkg::CFG_CAPACITY_LOG2:  cap_log2_r = data[4:0];
            brw_pkg::CFG_MAX_MSG_LENGTH: max_len_r  = data[13:0];
            brw_pkg::CFG_PADDING_TYPE:   pad_type_r = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait until every expected write has drained
    task automatic settle();
        in_valid <= 1'b0;
        while (ring_writes_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned lim;
        int unsigned len;
        int unsigned nwords;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                lim = 32'(max_len_r);
                if (ring_bytes() - 64'd8 < 64'(lim)) lim = 32'(ring_bytes() - 64'd8);
                len = $urandom_range(0, (lim < 48) ? lim : 48);
                if (lim <= 120 && $urandom_range(0, 9) == 0) len = lim;
                nwords = (len + 7) / 8;
                // now and then stop early so the next start abandons the record
                if ($urandom_range(0, 9) == 0) nwords = $urandom_range(0, nwords);
                send_item(start_item($urandom_range(1, 32'h7FFF_FFFF), 16'(len)));
                repeat (nwords) send_item(word_item({$urandom, $urandom}));
                sent += nwords + 1;
            end else if (pick < 90) begin
                send_item(start_item($urandom, 16'($urandom_range(0, 16'hFFFF))));
                sent++;
            end else begin
                send_item(word_item({$urandom, $urandom}));
                sent++;
            end
        end
    endtask

    initial begin
        t_stim_row directed_rows[$];
        t_stim_row row;

        cap_log2_r  = brw_pkg::CAPACITY_LOG2_RST;
        max_len_r   = brw_pkg::MAX_MSG_LENGTH_RST;
        pad_type_r  = brw_pkg::PADDING_TYPE_RST;
        ring_tail   = '0;
        rec_start   = '0;
        rec_end     = '0;
        wr_ptr      = '0;
        bytes_due   = '0;
        record_open = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        directed_rows.push_back(item_row(word_item('1), 1'b1));            // stray payload
        directed_rows.push_back(item_row(start_item(32'd0, 16'd0), 1'b1)); // type zero
        directed_rows.push_back(item_row(start_item(32'h8000_0000, 16'd8), 1'b1));
        directed_rows.push_back(item_row(start_item(32'd1, 16'd8193), 1'b1));
        directed_rows.push_back(item_row(start_item(32'h7FFF_FFFF, 16'hFFFF), 1'b1));
        directed_rows.push_back(item_row(start_item(32'h7FFF_FFFF, 16'd0), 1'b0)); // empty
        directed_rows.push_back(item_row(start_item(32'd5, 16'd13), 1'b0));
        directed_rows.push_back(item_row(word_item('1), 1'b0));
        directed_rows.push_back(item_row(word_item('1), 1'b0));           // short final word
        directed_rows.push_back(item_row(start_item(32'd7, 16'd16), 1'b0));
        directed_rows.push_back(item_row(word_item(64'h0123_4567_89AB_CDEF), 1'b0));
        directed_rows.push_back(item_row(start_item(32'd9, 16'd3), 1'b0)); // abandons open one
        directed_rows.push_back(item_row(word_item('1), 1'b0));
        directed_rows.push_back(item_row(word_item(64'd0), 1'b1));        // stray after close
        directed_rows.push_back(cfg_row(brw_pkg::CFG_CAPACITY_LOG2, 32'd6));
        directed_rows.push_back(cfg_row(brw_pkg::CFG_MAX_MSG_LENGTH, 32'd64));
        directed_rows.push_back(cfg_row(brw_pkg::CFG_PADDING_TYPE, 32'h8000_0000));
        directed_rows.push_back(item_row(start_item(32'd3, 16'd57), 1'b1)); // longer than ring
        directed_rows.push_back(item_row(start_item(32'd3, 16'd56), 1'b0)); // whole ring, wraps
        for (int k = 0; k < 7; k++) begin
            directed_rows.push_back(item_row(word_item({$urandom, $urandom}), 1'b0));
        end
        directed_rows.push_back(cfg_row(brw_pkg::CFG_CAPACITY_LOG2, 32'd0)); // clamps up
        directed_rows.push_back(item_row(start_item(32'd4, 16'd8), 1'b0));
        directed_rows.push_back(item_row(word_item({$urandom, $urandom}), 1'b0));

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                settle();
                send_cfg(row.cfg_index, row.cfg_data);
            end else begin
                send_item(row.item, row.expect_reject);
            end
        end

        settle();
        send_cfg(brw_pkg::CFG_CAPACITY_LOG2, 32'd7);
        send_cfg(brw_pkg::CFG_MAX_MSG_LENGTH, 32'd120);
        send_cfg(brw_pkg::CFG_PADDING_TYPE, 32'h7FFF_FFFF);
        random_traffic(100);

        settle();
        send_idle_pct = 83;
        recv_idle_pct = 27;
        send_cfg(brw_pkg::CFG_CAPACITY_LOG2, 32'd31);                     // clamps down
        send_cfg(brw_pkg::CFG_MAX_MSG_LENGTH, 32'd8192);
        send_cfg(brw_pkg::CFG_PADDING_TYPE, $urandom);
        // longest message, left open and abandoned by the next start
        send_item(start_item(32'h7FFF_FFFF, 16'd8192));
        repeat (4) send_item(word_item({$urandom, $urandom}));
        random_traffic(100);

        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_cfg(brw_pkg::CFG_CAPACITY_LOG2, 32'd9);
        send_cfg(brw_pkg::CFG_MAX_MSG_LENGTH, 32'd200);
        send_cfg(brw_pkg::CFG_PADDING_TYPE, 32'hFFFF_FFFF);
        send_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        random_traffic(100);

        settle();
        send_cfg(brw_pkg::CFG_CAPACITY_LOG2, 32'd6);
        send_cfg(brw_pkg::CFG_MAX_MSG_LENGTH, 32'd0);
        // long receiver stall while items keep coming, so the input backs up
        fork
            begin
                holding <= 1'b1;
                repeat (400) @(posedge clk);
                holding <= 1'b0;
            end
        join_none
        random_traffic(40);

        settle();
        repeat (16) @(posedge clk);

        $display("tb: %0d items in, %0d ring writes checked (%0d rejects), %0d register writes",
                 items_accepted, writes_checked, rejects_checked, cfg_writes);
        $display("tb: rings of 64 B to 64 KiB, wrap padding, empty and abandoned records");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/brw_pkg.sv
rtl/brw_front.sv
rtl/brw_queue.sv
rtl/brw_back.sv
rtl/broadcast_ring_record_writer_top.sv
tb/tb.sv
